// ===== rtl/irt_pkg.sv =====
// ----------------------------------------------------------------------------
// irt_pkg
// Shared types and constants of the in-order release tracker.
// ----------------------------------------------------------------------------
package irt_pkg;

  localparam int SEQ_W       = 32;
  localparam int MAX_RESULTS = 64;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  // Input function codes.
  localparam logic FUNC_ISSUE = 1'b0;
  localparam logic FUNC_DONE  = 1'b1;

  typedef enum logic [1:0] {
    KIND_ISSUED   = 2'd0,
    KIND_RELEASED = 2'd1,
    KIND_REJECTED = 2'd2
  } kind_t;

  // Shared adder operation: a - b or a + 1.
  typedef enum logic {
    ALU_INC = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  // Configuration register indexes.
  localparam logic REG_NODE_IS_SOURCE = 1'b0;

endpackage

// ===== rtl/in_order_release_tracker.sv =====
// ----------------------------------------------------------------------------
// in_order_release_tracker
// Hands out frame sequence numbers and releases completed frames in order.
// ----------------------------------------------------------------------------
// After reset the block sweeps every entry of its pending bitmap and takes
// no item until then; configuration writes are taken at any time. It takes
// no new item while one is in progress, and a stall on the result side holds
// the item in progress. The pace is set by the single read port of the
// pending bitmap, which the sequencer reads once per drained release, and by
// the one shared 32-bit adder that forms the window offset and every sequence
// number increment. Results leave through an output register, and the last
// result of an item carries out_last.
module in_order_release_tracker
  import irt_pkg::*;
#(
  parameter int WINDOW = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  // Input channel
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_func,
  input  logic [SEQ_W-1:0] in_seq_no,
  // Result channel
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       out_kind,
  output logic [SEQ_W-1:0] out_seq_out,
  output logic             out_release_action,
  output logic             out_last,
  // Configuration port
  input  logic             cfg_psel,
  input  logic             cfg_penable,
  input  logic             cfg_pwrite,
  input  logic [2:0]       cfg_paddr,
  input  logic [31:0]      cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int AW = $clog2(WINDOW);

  typedef enum logic [8:0] {
    S_CLR  = 9'b000000001,
    S_IDLE = 9'b000000010,
    S_ISS  = 9'b000000100,
    S_OFF  = 9'b000001000,
    S_RD   = 9'b000010000,
    S_DEC  = 9'b000100000,
    S_DRD  = 9'b001000000,
    S_DCK  = 9'b010000000,
    S_FIN  = 9'b100000000
  } state_t;

  state_t           state_r, state_nxt;
  logic [SEQ_W-1:0] seq_r, seq_nxt;
  logic [SEQ_W-1:0] next_issue_r, next_issue_nxt;
  logic [SEQ_W-1:0] next_rel_r, next_rel_nxt;
  logic [AW-1:0]    ptr_r, ptr_nxt;
  logic [AW-1:0]    off_r, off_nxt;
  logic             inwin_r, inwin_nxt;
  logic [AW-1:0]    addr_r, addr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             nis_r, nis_nxt;

  // Result held back until it is known whether another follows it.
  logic             hold_vld_r, hold_vld_nxt;
  kind_t            hold_kind_r, hold_kind_nxt;
  logic [SEQ_W-1:0] hold_seq_r, hold_seq_nxt;
  logic             hold_act_r, hold_act_nxt;

  logic             out_valid_r, out_valid_nxt;
  kind_t            out_kind_r, out_kind_nxt;
  logic [SEQ_W-1:0] out_seq_r, out_seq_nxt;
  logic             out_act_r, out_act_nxt;
  logic             out_last_r, out_last_nxt;

  alu_op_t          alu_op;
  logic [SEQ_W-1:0] alu_a, alu_b, alu_res;

  logic             bm_rd_en, bm_rd_data, bm_wr_en, bm_wr_data, bm_ready;
  logic [AW-1:0]    bm_rd_addr, bm_wr_addr;

  logic [AW:0]      ring_sum;
  logic [AW-1:0]    ring_addr;
  logic [AW-1:0]    ptr_inc;
  logic             out_free;
  logic             cfg_wr;

  irt_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  irt_bitmap #(
    .WINDOW (WINDOW),
    .AW     (AW)
  ) u_bitmap (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (bm_rd_en),
    .rd_addr (bm_rd_addr),
    .rd_data (bm_rd_data),
    .wr_en   (bm_wr_en),
    .wr_addr (bm_wr_addr),
    .wr_data (bm_wr_data),
    .ready   (bm_ready)
  );

  // Ring slot of the completed frame: release pointer plus offset, wrapped.
  assign ring_sum  = {1'b0, ptr_r} + {1'b0, off_r};
  assign ring_addr = (ring_sum >= (AW + 1)'(WINDOW)) ?
                     AW'(ring_sum - (AW + 1)'(WINDOW)) : ring_sum[AW-1:0];
  assign ptr_inc   = (ptr_r == AW'(WINDOW - 1)) ? '0 : ptr_r + AW'(1);

  assign out_free  = ~out_valid_r | ~out_stall;

  always_comb begin
    alu_op = ALU_INC;
    alu_a  = next_rel_r;
    alu_b  = next_rel_r;
    case (state_r)
      S_OFF: begin
        alu_op = ALU_SUB;
        alu_a  = seq_r;
      end
      S_ISS: begin
        alu_a = next_issue_r;
      end
      default: begin
        alu_a = next_rel_r;
      end
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    seq_nxt        = seq_r;
    next_issue_nxt = next_issue_r;
    next_rel_nxt   = next_rel_r;
    ptr_nxt        = ptr_r;
    off_nxt        = off_r;
    inwin_nxt      = inwin_r;
    addr_nxt       = addr_r;
    cnt_nxt        = cnt_r;
    nis_nxt        = nis_r;
    hold_vld_nxt   = hold_vld_r;
    hold_kind_nxt  = hold_kind_r;
    hold_seq_nxt   = hold_seq_r;
    hold_act_nxt   = hold_act_r;
    out_valid_nxt  = out_valid_r & out_stall;
    out_kind_nxt   = out_kind_r;
    out_seq_nxt    = out_seq_r;
    out_act_nxt    = out_act_r;
    out_last_nxt   = out_last_r;
    bm_rd_en       = 1'b0;
    bm_rd_addr     = ptr_r;
    bm_wr_en       = 1'b0;
    bm_wr_addr     = ptr_r;
    bm_wr_data     = 1'b0;

    if (cfg_wr) begin
      nis_nxt = cfg_pwdata[0];
    end

    case (state_r)
      S_CLR: begin
        if (bm_ready) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        cnt_nxt = '0;
        if (in_valid) begin
          seq_nxt   = in_seq_no;
          state_nxt = (in_func == FUNC_ISSUE) ? S_ISS : S_OFF;
        end
      end
      S_ISS: begin
        hold_vld_nxt   = 1'b1;
        hold_kind_nxt  = KIND_ISSUED;
        hold_seq_nxt   = next_issue_r;
        hold_act_nxt   = 1'b0;
        cnt_nxt        = CNT_W'(1);
        next_issue_nxt = alu_res;
        state_nxt      = S_FIN;
      end
      S_OFF: begin
        inwin_nxt = alu_res < SEQ_W'(WINDOW);
        off_nxt   = alu_res[AW-1:0];
        state_nxt = S_RD;
      end
      S_RD: begin
        bm_rd_en   = 1'b1;
        bm_rd_addr = ring_addr;
        addr_nxt   = ring_addr;
        state_nxt  = S_DEC;
      end
      S_DEC: begin
        // The bitmap data is stale when out of window; that case rejects anyway.
        if (!inwin_r || bm_rd_data) begin
          hold_vld_nxt  = 1'b1;
          hold_kind_nxt = KIND_REJECTED;
          hold_seq_nxt  = seq_r;
          hold_act_nxt  = 1'b0;
          cnt_nxt       = CNT_W'(1);
        end else if (off_r == '0) begin
          hold_vld_nxt  = 1'b1;
          hold_kind_nxt = KIND_RELEASED;
          hold_seq_nxt  = next_rel_r;
          hold_act_nxt  = nis_r;
          cnt_nxt       = CNT_W'(1);
          next_rel_nxt  = alu_res;
          ptr_nxt       = ptr_inc;
        end else begin
          bm_wr_en   = 1'b1;
          bm_wr_addr = addr_r;
          bm_wr_data = 1'b1;
        end
        state_nxt = S_DRD;
      end
      S_DRD: begin
        bm_rd_en   = 1'b1;
        bm_rd_addr = ptr_r;
        state_nxt  = S_DCK;
      end
      S_DCK: begin
        if (bm_rd_data && (cnt_r < CNT_W'(MAX_RESULTS))) begin
          if (!hold_vld_r || out_free) begin
            if (hold_vld_r) begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = hold_kind_r;
              out_seq_nxt   = hold_seq_r;
              out_act_nxt   = hold_act_r;
              out_last_nxt  = 1'b0;
            end
            hold_vld_nxt  = 1'b1;
            hold_kind_nxt = KIND_RELEASED;
            hold_seq_nxt  = next_rel_r;
            hold_act_nxt  = nis_r;
            cnt_nxt       = cnt_r + CNT_W'(1);
            bm_wr_en      = 1'b1;
            bm_wr_addr    = ptr_r;
            bm_wr_data    = 1'b0;
            next_rel_nxt  = alu_res;
            ptr_nxt       = ptr_inc;
            state_nxt     = S_DRD;
          end
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!hold_vld_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = hold_kind_r;
          out_seq_nxt   = hold_seq_r;
          out_act_nxt   = hold_act_r;
          out_last_nxt  = 1'b1;
          hold_vld_nxt  = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      next_issue_r <= SEQ_W'(1);
      next_rel_r   <= SEQ_W'(1);
      ptr_r        <= '0;
      cnt_r        <= '0;
      nis_r        <= 1'b0;
      hold_vld_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      next_issue_r <= next_issue_nxt;
      next_rel_r   <= next_rel_nxt;
      ptr_r        <= ptr_nxt;
      cnt_r        <= cnt_nxt;
      nis_r        <= nis_nxt;
      hold_vld_r   <= hold_vld_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seq_r       <= seq_nxt;
    off_r       <= off_nxt;
    inwin_r     <= inwin_nxt;
    addr_r      <= addr_nxt;
    hold_kind_r <= hold_kind_nxt;
    hold_seq_r  <= hold_seq_nxt;
    hold_act_r  <= hold_act_nxt;
    out_kind_r  <= out_kind_nxt;
    out_seq_r   <= out_seq_nxt;
    out_act_r   <= out_act_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign in_stall           = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_kind           = out_kind_r;
  assign out_seq_out        = out_seq_r;
  assign out_release_action = out_act_r;
  assign out_last           = out_last_r;

  // Register index is taken from bit 2 of the byte address.
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & (cfg_paddr[2] == REG_NODE_IS_SOURCE);
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_NODE_IS_SOURCE) ? {31'd0, nis_r} : 32'd0;

  // An item is taken only with nothing left over from the previous one.
  a_idle_empty : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !hold_vld_r)
    else $error("result left pending while idle");

  // An input never causes more results than the drain limit allows.
  a_cnt_limit : assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_RESULTS))
    else $error("result count over limit");

  // Every release advances the release point by exactly one.
  a_rel_step : assert property (@(posedge clk) disable iff (!rst_n)
    (next_rel_r != $past(next_rel_r)) |-> (next_rel_r == $past(next_rel_r) + SEQ_W'(1)))
    else $error("release point skipped");

  // A stalled result item stays in place until it is taken.
  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_kind_r) &&
      $stable(out_seq_r) && $stable(out_act_r) && $stable(out_last_r)))
    else $error("stalled result changed");

endmodule

// ===== rtl/irt_alu.sv =====
// ----------------------------------------------------------------------------
// irt_alu
// Shared 32-bit adder: computes a - b or a + 1 through one carry chain.
// ----------------------------------------------------------------------------
module irt_alu
  import irt_pkg::*;
(
  input  alu_op_t          op,
  input  logic [SEQ_W-1:0] a,
  input  logic [SEQ_W-1:0] b,
  output logic [SEQ_W-1:0] res
);

  logic [SEQ_W-1:0] b_sel;

  // a - b is a + ~b + 1; an increment is a + 0 + 1.
  assign b_sel = (op == ALU_SUB) ? ~b : '0;
  assign res   = a + b_sel + SEQ_W'(1);

endmodule

// ===== rtl/irt_bitmap.sv =====
// ----------------------------------------------------------------------------
// irt_bitmap
// Ring of pending-completion bits with a registered read port and a clearing
// sweep after reset.
// ----------------------------------------------------------------------------
module irt_bitmap
  import irt_pkg::*;
#(
  parameter int WINDOW = 64,
  parameter int AW     = $clog2(WINDOW)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic          rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic          wr_data,
  output logic          ready
);

  logic          mem [WINDOW];
  logic          rd_data_r;
  logic [AW-1:0] clr_idx_r;
  logic [AW-1:0] clr_idx_nxt;
  logic          clr_busy_r;
  logic          clr_busy_nxt;
  logic          we;
  logic [AW-1:0] wa;
  logic          wd;

  always_comb begin
    clr_idx_nxt  = clr_idx_r;
    clr_busy_nxt = clr_busy_r;
    if (clr_busy_r) begin
      clr_idx_nxt = clr_idx_r + AW'(1);
      if (clr_idx_r == AW'(WINDOW - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r  <= '0;
      clr_busy_r <= 1'b1;
    end else begin
      clr_idx_r  <= clr_idx_nxt;
      clr_busy_r <= clr_busy_nxt;
    end
  end

  assign we = clr_busy_r | wr_en;
  assign wa = clr_busy_r ? clr_idx_r : wr_addr;
  assign wd = clr_busy_r ? 1'b0 : wr_data;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
  assign ready   = ~clr_busy_r;

endmodule

// ===== sim/in_order_release_tracker_tb.sv =====
// ----------------------------------------------------------------------------
// in_order_release_tracker_tb
// Drives issue and completion items into the release tracker, including
// duplicate, stale, out-of-window and long-run completions. It predicts every
// issued, released and rejected frame and checks each result item in order
// while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module in_order_release_tracker_tb;
  import irt_pkg::*;

  localparam int WINDOW        = 64;
  localparam int SETTLE_CYCLES = 16;
  localparam int TIMEOUT       = 5_000_000;

  localparam logic [2:0] ADDR_NODE_IS_SOURCE = {REG_NODE_IS_SOURCE, 2'b00};
  // Index 1 has no register behind it, so writes there must be dropped.
  localparam logic [2:0] ADDR_UNMAPPED       = 3'd4;

  typedef struct {
    kind_t             kind;
    logic [SEQ_W-1:0]  seq;
    logic              action;
    logic              last;
  } frame_result_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             in_func = FUNC_ISSUE;
  logic [SEQ_W-1:0] in_seq_no = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [1:0]       out_kind;
  logic [SEQ_W-1:0] out_seq_out;
  logic             out_release_action;
  logic             out_last;
  logic             cfg_psel = 1'b0;
  logic             cfg_penable = 1'b0;
  logic             cfg_pwrite = 1'b0;
  logic [2:0]       cfg_paddr = '0;
  logic [31:0]      cfg_pwdata = '0;
  logic [31:0]      cfg_prdata;
  logic             cfg_pready;

  // Predicted tracker state.
  logic [SEQ_W-1:0]  issue_ptr = 32'd1;
  logic [SEQ_W-1:0]  release_ptr = 32'd1;
  logic [WINDOW-1:0] done_map = '0;
  logic              source_mode = 1'b0;

  frame_result_t awaited_results [$];
  int            mismatch_count = 0;
  int            accepted_items = 0;
  int            send_idle_pct = 0;
  int            stall_pct = 0;
  int            out_hold_cycles = 0;

  in_order_release_tracker #(.WINDOW(WINDOW)) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_func            (in_func),
    .in_seq_no          (in_seq_no),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_seq_out        (out_seq_out),
    .out_release_action (out_release_action),
    .out_last           (out_last),
    .cfg_psel           (cfg_psel),
    .cfg_penable        (cfg_penable),
    .cfg_pwrite         (cfg_pwrite),
    .cfg_paddr          (cfg_paddr),
    .cfg_pwdata         (cfg_pwdata),
    .cfg_prdata         (cfg_prdata),
    .cfg_pready         (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic push_result(input kind_t kind, input logic [SEQ_W-1:0] seq,
                             input logic action);
    frame_result_t r;
    r.kind   = kind;
    r.seq    = seq;
    r.action = action;
    r.last   = 1'b0;
    awaited_results.push_back(r);
  endtask

  task automatic release_oldest();
    push_result(KIND_RELEASED, release_ptr, source_mode);
    done_map    = done_map >> 1;
    release_ptr = release_ptr + 32'd1;
  endtask

  // Updates the predicted state for one accepted item and queues its results.
  task automatic predict_frame_item(input logic func, input logic [SEQ_W-1:0] seq);
    logic [SEQ_W-1:0] off;
    int               base_count;
    int               produced;
    frame_result_t    tail;
    base_count = awaited_results.size();
    if (func == FUNC_ISSUE) begin
      push_result(KIND_ISSUED, issue_ptr, 1'b0);
      issue_ptr = issue_ptr + 32'd1;
    end else begin
      off = seq - release_ptr;
      if (off >= WINDOW || done_map[off[5:0]]) begin
        push_result(KIND_REJECTED, seq, 1'b0);
      end else if (off == 0) begin
        release_oldest();
      end else begin
        done_map[off[5:0]] = 1'b1;
      end
      // The drain is capped so that one item never causes more than
      // MAX_RESULTS result items.
      while (awaited_results.size() - base_count < MAX_RESULTS && done_map[0])
        release_oldest();
    end
    produced = awaited_results.size() - base_count;
    if (produced > 0) begin
      tail = awaited_results.pop_back();
      tail.last = 1'b1;
      awaited_results.push_back(tail);
    end
  endtask

  task automatic send_item(input logic func, input logic [SEQ_W-1:0] seq);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid  <= 1'b1;
    in_func   <= func;
    in_seq_no <= seq;
    do @(posedge clk); while (in_stall);
    accepted_items++;
    predict_frame_item(func, seq);
  endtask

  task automatic send_issue();
    send_item(FUNC_ISSUE, $urandom);
  endtask

  task automatic send_done(input logic [SEQ_W-1:0] seq);
    send_item(FUNC_DONE, seq);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    // A completion that only marks a frame pending leaves nothing to wait on.
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_access(input logic write, input logic [2:0] addr,
                            input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= write;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (write && addr == ADDR_NODE_IS_SOURCE)
      source_mode = data[0];
    if (!write && cfg_prdata !== {31'b0, source_mode}) begin
      $display("%0t: node_is_source read expected %0h actual %0h",
               $time, {31'b0, source_mode}, cfg_prdata);
      mismatch_count++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Issues a few numbers, then completes the frames at the release point in a
  // shuffled order, now and then repeating one that was already sent.
  task automatic send_batch(input int span);
    logic [SEQ_W-1:0] order [64];
    logic [SEQ_W-1:0] base;
    logic [SEQ_W-1:0] swap;
    int               i;
    int               j;
    repeat ($urandom_range((span < 4) ? span : 4)) send_issue();
    base = release_ptr;
    for (i = 0; i < span; i++) order[i] = base + i;
    for (i = span - 1; i > 0; i--) begin
      j        = $urandom_range(i);
      swap     = order[i];
      order[i] = order[j];
      order[j] = swap;
    end
    for (i = 0; i < span; i++) begin
      send_done(order[i]);
      if ($urandom_range(9) == 0) send_done(order[$urandom_range(i)]);
    end
  endtask

  task automatic send_noise();
    case ($urandom_range(3))
      0: send_issue();
      1: send_done($urandom);
      2: send_done(release_ptr + $urandom_range(70));
      default: send_done(release_ptr - $urandom_range(4, 1));
    endcase
  endtask

  task automatic run_random(input int count);
    int target;
    int halfway;
    target  = accepted_items + count;
    halfway = accepted_items + count / 2;
    while (accepted_items < target) begin
      if ($urandom_range(99) < 70)
        send_batch(($urandom_range(19) == 0) ? $urandom_range(63, 20) : $urandom_range(8, 1));
      else
        send_noise();
      if (halfway != 0 && accepted_items >= halfway) begin
        halfway = 0;
        wait_drained();
      end
    end
  endtask

  task automatic test_directed();
    cfg_access(1'b1, ADDR_NODE_IS_SOURCE, 32'hFFFF_FFFE);
    cfg_access(1'b0, ADDR_NODE_IS_SOURCE, 32'h0);
    repeat (3) send_issue();
    send_done(release_ptr);
    send_done(release_ptr + 32'd1);
    send_done(release_ptr + 32'd1);
    send_done(release_ptr);
    send_done(release_ptr - 32'd1);
    send_done(release_ptr + WINDOW - 1);
    send_done(release_ptr + WINDOW);
    send_done(32'h0000_0000);
    send_done(32'hFFFF_FFFF);
    send_done(32'hAAAA_AAAA);
    send_done(32'h5555_5555);
    wait_drained();
    cfg_access(1'b1, ADDR_NODE_IS_SOURCE, 32'h0000_0001);
    cfg_access(1'b0, ADDR_NODE_IS_SOURCE, 32'h0);
    send_done(release_ptr);
    wait_drained();
    cfg_access(1'b1, ADDR_UNMAPPED, 32'h0000_0000);
    cfg_access(1'b0, ADDR_NODE_IS_SOURCE, 32'h0);
    send_done(release_ptr);
    send_issue();
    wait_drained();
  endtask

  // Fills the whole window behind the release point, so that the final
  // in-order completion drains the largest possible run.
  task automatic test_long_drain();
    logic [SEQ_W-1:0] base;
    int               i;
    base = release_ptr;
    for (i = WINDOW - 1; i > 0; i--) send_done(base + i);
    send_done(base);
    wait_drained();
  endtask

  task automatic test_backpressure();
    send_idle_pct   = 0;
    stall_pct       = 0;
    out_hold_cycles = 400;
    send_batch(8);
    send_batch(8);
    wait_drained();
  endtask

  task automatic test_idle_phases();
    int          send_pcts [4] = '{0, 68, 0, 10};
    int          stall_pcts [4] = '{0, 0, 68, 10};
    logic [31:0] mode;
    int          phase;
    for (phase = 0; phase < 4; phase++) begin
      mode = $urandom;
      if (phase < 3) mode[0] = (phase != 1);
      cfg_access(1'b1, ADDR_NODE_IS_SOURCE, mode);
      send_idle_pct = send_pcts[phase];
      stall_pct     = stall_pcts[phase];
      run_random(36);
      wait_drained();
    end
  endtask

  // Result side: random stall, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (out_hold_cycles > 0) begin
      out_hold_cycles = out_hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    frame_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result kind %0d seq %0h", $time, out_kind, out_seq_out);
        mismatch_count++;
      end else begin
        exp_r = awaited_results.pop_front();
        if (out_kind !== exp_r.kind || out_seq_out !== exp_r.seq ||
            out_release_action !== exp_r.action || out_last !== exp_r.last) begin
          $display("%0t: expected kind %0d seq %0h action %0b last %0b",
                   $time, exp_r.kind, exp_r.seq, exp_r.action, exp_r.last);
          $display("%0t: actual   kind %0d seq %0h action %0b last %0b",
                   $time, out_kind, out_seq_out, out_release_action, out_last);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_long_drain();
    test_backpressure();
    test_idle_phases();
    wait_drained();
    if (mismatch_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  initial begin
    #(TIMEOUT);
    $display("tb: failure");
    $finish;
  end

endmodule
